### src/wtt_pkg.sv
// Shared constants, types and helpers for the windowed trapezoid totalizer.
`timescale 1ns / 1ps
package wtt_pkg;

   // Ring depth; the pointer and window counter widths follow from it.
   localparam int MAX_WINDOW = 16;
   localparam int PTR_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int LEN_W      = 5;
   localparam int CNT_W      = (PTR_W + 1 > LEN_W) ? PTR_W + 1 : LEN_W;

   localparam int SAMPLE_W   = 32;
   localparam int GAIN_W     = 24;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GAIN       = 3'd0,
      CSR_HIGH_LIMIT = 3'd1,
      CSR_LOW_LIMIT  = 3'd2,
      CSR_WIN_LEN    = 3'd3,
      CSR_AUTO_MODE  = 3'd4
   } csr_addr_type;

   localparam logic signed [GAIN_W-1:0]   GAIN_RESET       = 24'sd65536;
   localparam logic signed [SAMPLE_W-1:0] HIGH_LIMIT_RESET = 32'sd6553600;
   localparam logic signed [SAMPLE_W-1:0] LOW_LIMIT_RESET  = 32'sd0;
   localparam logic [LEN_W-1:0]           WIN_LEN_RESET    = 5'd10;

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (v > hi) begin
         sat32 = 32'sh7fffffff;
      end else if (v < lo) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[SAMPLE_W-1:0];
      end
   endfunction

endpackage

### src/windowed_trapezoid_totalizer.sv
// Top level of the windowed trapezoid totalizer: one sample in, one total out.
`timescale 1ns / 1ps
// Usage
//   req_* : one signed Q16.16 sample per beat on req_tdata[31:0].
//   rsp_* : one result per sample; rsp_tdata[31:0] is the saturated Q16.16 total,
//           rsp_tdata[32] is the out-of-limits flag, bits above are zero.
//   csr_* : write-only registers (gain, high limit, low limit, window length,
//           auto mode) at indexes 0..4; write them only while the block is idle.
// Timing
//   A sample is taken into an input register, then the trapezoid, gain multiply,
//   rounding, saturation and ring update run combinationally into the result
//   register and the totalizer state: rsp_tvalid rises once the sample moves on
//   from the input register into the result register.
//   Throughput is one sample per cycle while rsp_tready stays high; the loop
//   from the carried sum through the multiplier and back sets that figure.
// Reset
//   Synchronous reset clears the ring, pointer, previous sample, carried sum,
//   held total and both pipeline valids, and loads the register defaults.
// Backpressure
//   While rsp_tready is low the result holds; the input register still takes
//   one more beat, then req_tready drops until the result moves.
module windowed_trapezoid_totalizer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [wtt_pkg::REQ_DATA_W-1:0]  req_tdata,   // [31:0] sample
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [wtt_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [31:0] total, [32] out_of_limits
   input  logic                            csr_we,
   input  logic [wtt_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [wtt_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   logic signed [wtt_pkg::GAIN_W-1:0]   gain_ff;
   logic signed [wtt_pkg::SAMPLE_W-1:0] high_limit_ff;
   logic signed [wtt_pkg::SAMPLE_W-1:0] low_limit_ff;
   logic [wtt_pkg::LEN_W-1:0]           win_len_ff;
   logic                                auto_mode_ff;

   // pipeline
   logic                                s1_valid_ff;
   logic signed [wtt_pkg::SAMPLE_W-1:0] s1_sample_ff;
   logic                                rsp_valid_ff;
   logic signed [wtt_pkg::SAMPLE_W-1:0] rsp_total_ff;
   logic                                rsp_flag_ff;

   // totalizer state
   logic signed [wtt_pkg::SAMPLE_W-1:0] ring_ff [wtt_pkg::MAX_WINDOW];
   logic [wtt_pkg::PTR_W-1:0]           ring_ptr_ff;
   logic signed [wtt_pkg::SAMPLE_W-1:0] prev_sample_ff;
   logic signed [wtt_pkg::SAMPLE_W-1:0] carried_ff;
   logic signed [wtt_pkg::SAMPLE_W-1:0] held_total_ff;

   // next values
   logic [wtt_pkg::PTR_W-1:0]           ring_ptr_in;
   logic signed [wtt_pkg::SAMPLE_W-1:0] carried_in;
   logic signed [wtt_pkg::SAMPLE_W-1:0] total_in;
   logic                                flag_in;

   logic                                advance;
   logic                                load;
   logic                                fire;
   logic                                step;

   logic signed [wtt_pkg::SAMPLE_W:0]   trap_sum;
   logic signed [wtt_pkg::SAMPLE_W:0]   trap;
   logic signed [wtt_pkg::SAMPLE_W+1:0] acc;
   logic signed [57:0]                  prod;
   logic signed [57:0]                  prod_rnd;
   logic signed [41:0]                  scaled;
   logic signed [wtt_pkg::SAMPLE_W-1:0] total_auto;
   logic signed [wtt_pkg::SAMPLE_W-1:0] oldest;
   logic signed [wtt_pkg::SAMPLE_W:0]   diff;
   logic [wtt_pkg::CNT_W-1:0]           len_raw;
   logic [wtt_pkg::CNT_W-1:0]           len_eff;
   logic [wtt_pkg::CNT_W-1:0]           ptr_next;

   // Handshake: result register frees when empty or taken; input register
   // frees when empty or moving into the result register.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign load       = req_tvalid && req_tready;
   assign fire       = s1_valid_ff && advance;
   assign step       = fire && auto_mode_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(wtt_pkg::RSP_DATA_W - wtt_pkg::SAMPLE_W - 1){1'b0}},
                        rsp_flag_ff, rsp_total_ff};

   // Trapezoid, gain and round half up to Q16.16.
   always_comb begin
      trap_sum   = {s1_sample_ff[wtt_pkg::SAMPLE_W-1], s1_sample_ff}
                 + {prev_sample_ff[wtt_pkg::SAMPLE_W-1], prev_sample_ff};
      trap       = trap_sum >>> 1;
      acc        = {{2{carried_ff[wtt_pkg::SAMPLE_W-1]}}, carried_ff}
                 + {trap[wtt_pkg::SAMPLE_W], trap};
      prod       = gain_ff * acc;
      prod_rnd   = prod + 58'sd32768;
      scaled     = prod_rnd[57:16];
      total_auto = wtt_pkg::sat32(64'(scaled));

      // Drop the oldest entry from the carried sum.
      oldest     = ring_ff[ring_ptr_ff];
      diff       = {total_auto[wtt_pkg::SAMPLE_W-1], total_auto}
                 - {oldest[wtt_pkg::SAMPLE_W-1], oldest};
      carried_in = wtt_pkg::sat32(64'(diff));

      // Clamp the window length to [1, MAX_WINDOW] and wrap the pointer.
      len_raw = wtt_pkg::CNT_W'(win_len_ff);
      if (len_raw == '0) begin
         len_eff = wtt_pkg::CNT_W'(1);
      end else if (len_raw > wtt_pkg::CNT_W'(wtt_pkg::MAX_WINDOW)) begin
         len_eff = wtt_pkg::CNT_W'(wtt_pkg::MAX_WINDOW);
      end else begin
         len_eff = len_raw;
      end
      ptr_next = wtt_pkg::CNT_W'(ring_ptr_ff) + wtt_pkg::CNT_W'(1);
      if (ptr_next >= len_eff) begin
         ring_ptr_in = '0;
      end else begin
         ring_ptr_in = ptr_next[wtt_pkg::PTR_W-1:0];
      end

      total_in = auto_mode_ff ? total_auto : held_total_ff;
      flag_in  = (total_in > high_limit_ff) || (total_in < low_limit_ff);
   end

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff       <= wtt_pkg::GAIN_RESET;
         high_limit_ff <= wtt_pkg::HIGH_LIMIT_RESET;
         low_limit_ff  <= wtt_pkg::LOW_LIMIT_RESET;
         win_len_ff    <= wtt_pkg::WIN_LEN_RESET;
         auto_mode_ff  <= 1'b1;
      end else if (csr_we) begin
         case (csr_addr)
            wtt_pkg::CSR_GAIN:       gain_ff       <= csr_wdata[wtt_pkg::GAIN_W-1:0];
            wtt_pkg::CSR_HIGH_LIMIT: high_limit_ff <= csr_wdata[wtt_pkg::SAMPLE_W-1:0];
            wtt_pkg::CSR_LOW_LIMIT:  low_limit_ff  <= csr_wdata[wtt_pkg::SAMPLE_W-1:0];
            wtt_pkg::CSR_WIN_LEN:    win_len_ff    <= csr_wdata[wtt_pkg::LEN_W-1:0];
            wtt_pkg::CSR_AUTO_MODE:  auto_mode_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Input and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_sample_ff <= req_tdata[wtt_pkg::SAMPLE_W-1:0];
      end
      if (fire) begin
         rsp_total_ff <= total_in;
         rsp_flag_ff  <= flag_in;
      end
   end

   // Totalizer state advances only in auto mode.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < wtt_pkg::MAX_WINDOW; i++) begin
            ring_ff[i] <= '0;
         end
         ring_ptr_ff    <= '0;
         prev_sample_ff <= '0;
         carried_ff     <= '0;
         held_total_ff  <= '0;
      end else if (step) begin
         ring_ff[ring_ptr_ff] <= s1_sample_ff;
         ring_ptr_ff          <= ring_ptr_in;
         prev_sample_ff       <= s1_sample_ff;
         carried_ff           <= carried_in;
         held_total_ff        <= total_auto;
      end
   end

`ifndef SYNTHESIS
   a_reset_clears_rsp : assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid set after reset");

   a_stall_holds_input : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_sample_ff)))
      else $error("input register changed while result stalled");

   a_manual_holds_state : assert property (@(posedge clock) disable iff (reset)
      (fire && !auto_mode_ff) |=> ($stable(ring_ptr_ff) && $stable(held_total_ff)
                                   && $stable(carried_ff)))
      else $error("state changed in manual mode");

   a_total_matches_held : assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_total_ff == held_total_ff))
      else $error("delivered total differs from held total");

   a_ptr_in_window : assert property (@(posedge clock) disable iff (reset)
      step |=> (wtt_pkg::CNT_W'(ring_ptr_ff) < wtt_pkg::CNT_W'(wtt_pkg::MAX_WINDOW)))
      else $error("ring pointer beyond ring depth");
`endif

endmodule

### tb/windowed_trapezoid_totalizer_tb.sv
// Testbench for the windowed trapezoid totalizer: random and corner samples, self-checking.
`timescale 1ns / 1ps
module windowed_trapezoid_totalizer_tb;
   import wtt_pkg::*;

   // Run shape
   localparam int ITEM_TARGET    = 500;
   localparam int IDLE_PCT       = 15;
   localparam int MAX_GAP        = 3;
   localparam int SETTLE_CYCLES  = 4;
   localparam int HOLDOFF_CYCLES = 200;
   localparam int HOLDOFF_PHASE  = 1;
   localparam int STEADY_PHASE   = 3;
   localparam int TIMEOUT_NS     = 1_000_000;

   // Arithmetic of the totalizer: Q16.16 samples, Q8.16 gain, round half up
   localparam int     FRAC_W     = 16;
   localparam longint ROUND_HALF = 64'sd1 <<< (FRAC_W - 1);
   localparam longint TOTAL_MAX  = 64'sd2147483647;
   localparam longint TOTAL_MIN  = -64'sd2147483648;
   localparam int     MID_SPAN   = 1 << 24;
   localparam int     SMALL_SPAN = 1 << 20;

   // A register index the block does not decode
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_INDEX = 3'd7;

   typedef struct {
      logic signed [SAMPLE_W-1:0] total;
      logic                       flag;
   } expected_beat_type;

   // Predicts each total from the samples and the register settings and
   // checks the result beats against the predictions in order.
   class total_scoreboard_type;
      logic signed [GAIN_W-1:0]   gain;
      logic signed [SAMPLE_W-1:0] high_limit;
      logic signed [SAMPLE_W-1:0] low_limit;
      logic [LEN_W-1:0]           win_len;
      logic                       auto_mode;
      logic signed [SAMPLE_W-1:0] window_store [MAX_WINDOW];
      logic [PTR_W-1:0]           ring_ptr;
      logic signed [SAMPLE_W-1:0] prev_sample;
      logic signed [SAMPLE_W-1:0] carried_sum;
      logic signed [SAMPLE_W-1:0] held_total;
      expected_beat_type          due_q [$];
      int unsigned                errors;
      int unsigned                checked;
      int unsigned                flagged;
      int unsigned                saturated;

      function void reset_state();
         gain        = GAIN_RESET;
         high_limit  = HIGH_LIMIT_RESET;
         low_limit   = LOW_LIMIT_RESET;
         win_len     = WIN_LEN_RESET;
         auto_mode   = 1'b1;
         foreach (window_store[i]) window_store[i] = '0;
         ring_ptr    = '0;
         prev_sample = '0;
         carried_sum = '0;
         held_total  = '0;
      endfunction

      function logic signed [SAMPLE_W-1:0] clamp32(longint v);
         if (v > TOTAL_MAX) return TOTAL_MAX[SAMPLE_W-1:0];
         if (v < TOTAL_MIN) return TOTAL_MIN[SAMPLE_W-1:0];
         return v[SAMPLE_W-1:0];
      endfunction

      function void apply_csr(logic [CSR_ADDR_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_GAIN:       gain       = value[GAIN_W-1:0];
            CSR_HIGH_LIMIT: high_limit = value[SAMPLE_W-1:0];
            CSR_LOW_LIMIT:  low_limit  = value[SAMPLE_W-1:0];
            CSR_WIN_LEN:    win_len    = value[LEN_W-1:0];
            CSR_AUTO_MODE:  auto_mode  = value[0];
            default: ;
         endcase
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] raw);
         longint            x;
         longint            trap;
         longint            acc;
         longint            rounded;
         int unsigned       len;
         int unsigned       slot;
         int unsigned       nxt;
         expected_beat_type want;
         if (auto_mode) begin
            x    = $signed(raw);
            len  = win_len;
            if (len == 0) len = 1;
            if (len > MAX_WINDOW) len = MAX_WINDOW;
            slot = ring_ptr;
            trap = (x + longint'(prev_sample)) >>> 1;
            acc  = longint'(carried_sum) + trap;
            rounded = (longint'(gain) * acc + ROUND_HALF) >>> FRAC_W;
            held_total = clamp32(rounded);
            if (rounded != longint'(held_total)) saturated++;
            carried_sum = clamp32(longint'(held_total) - longint'(window_store[slot]));
            prev_sample = raw;
            window_store[slot] = raw;
            nxt = slot + 1;
            ring_ptr = (nxt >= len) ? '0 : nxt[PTR_W-1:0];
         end
         want.total = held_total;
         want.flag  = (held_total > high_limit) || (held_total < low_limit);
         if (want.flag) flagged++;
         due_q.insert(due_q.size(), want);
      endfunction

      function void check_total(logic [RSP_DATA_W-1:0] beat);
         expected_beat_type want;
         if (due_q.size() == 0) begin
            errors++;
            $display("%0t: result beat with nothing expected: total %0d flag %0b",
                     $time, $signed(beat[SAMPLE_W-1:0]), beat[SAMPLE_W]);
            return;
         end
         want = due_q.pop_front();
         checked++;
         if (beat[SAMPLE_W-1:0] !== want.total) begin
            errors++;
            $display("%0t: total mismatch: expected %0d actual %0d",
                     $time, want.total, $signed(beat[SAMPLE_W-1:0]));
         end
         if (beat[SAMPLE_W] !== want.flag) begin
            errors++;
            $display("%0t: out_of_limits mismatch: expected %0b actual %0b",
                     $time, want.flag, beat[SAMPLE_W]);
         end
         if (beat[RSP_DATA_W-1:SAMPLE_W+1] !== '0) begin
            errors++;
            $display("%0t: padding mismatch: expected 0 actual %0h",
                     $time, beat[RSP_DATA_W-1:SAMPLE_W+1]);
         end
      endfunction

      function int unsigned pending();
         return due_q.size();
      endfunction
   endclass

   // Block ports; every input starts at a known value
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;    // [31:0] sample
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // [31:0] total, [32] out_of_limits
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Stimulus control shared with the receiver; written only by the main process
   logic        steady_run       = 1'b0;
   int unsigned holdoff_requests = 0;

   total_scoreboard_type book = new;
   int unsigned          samples_sent = 0;
   int unsigned          settings_used = 0;

   // Corner samples: both extremes twice (saturation), -1 LSB, the smallest step, 1.0, zero
   logic [SAMPLE_W-1:0] corner_samples [8] = '{
      32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
      32'hffffffff, 32'h00000001, 32'h00010000, 32'h00000000
   };

   windowed_trapezoid_totalizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Receiver: check every accepted result beat, then pick the next tready.
   // A hold-off request parks tready low for a long count so the block fills
   // and pushes back on the sender; steady runs keep tready high.
   int unsigned holdoff_left   = 0;
   int unsigned holdoffs_served = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) book.check_total(rsp_tdata);
         if (holdoff_left != 0) begin
            rsp_tready   <= 1'b0;
            holdoff_left <= holdoff_left - 1;
         end else if (holdoffs_served != holdoff_requests) begin
            rsp_tready      <= 1'b0;
            holdoffs_served <= holdoffs_served + 1;
            holdoff_left    <= HOLDOFF_CYCLES;
         end else if (steady_run) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Write one register while the block is idle, and mirror it in the predictor
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      book.apply_csr(index, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one sample and hold it until the block takes the beat
   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      book.note_sample(value);
      samples_sent++;
   endtask

   // Drop tvalid for a few cycles now and then, except in a steady run
   task automatic sender_gap();
      if (!steady_run && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every predicted total has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int pick;
      int v;
      pick = $urandom_range(9);
      if (pick <= 5) begin
         v = $urandom_range(0, 2 * SMALL_SPAN) - SMALL_SPAN;
      end else if (pick <= 7) begin
         v = $urandom;
      end else if (pick == 8) begin
         v = corner_samples[$urandom_range(7)];
      end else begin
         v = $urandom_range(0, 512) - 256;
      end
      return v;
   endfunction

   task automatic send_run(input int unsigned count);
      repeat (count) begin
         send_sample(pick_sample());
         sender_gap();
      end
   endtask

   // Random register settings; junk in the unused upper bits checks the masking
   task automatic pick_settings();
      int                    g;
      int                    lo;
      int                    hi;
      int                    swap;
      int unsigned           len;
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom;
      case ($urandom_range(3))
         0:       g = $urandom;
         1:       g = (1 << FRAC_W) + $urandom_range(0, 1 << FRAC_W) - (1 << (FRAC_W - 1));
         2:       g = $urandom_range(0, 1 << (FRAC_W + 1)) - (1 << FRAC_W);
         default: g = $urandom_range(1) ? 8388607 : -8388608;
      endcase
      csr_write(CSR_GAIN, {junk[CSR_DATA_W-1:GAIN_W], g[GAIN_W-1:0]});

      case ($urandom_range(3))
         0: begin
            lo = $urandom_range(0, 2 * MID_SPAN) - MID_SPAN;
            hi = $urandom_range(0, 2 * MID_SPAN) - MID_SPAN;
            if (lo > hi) begin
               swap = lo;
               lo   = hi;
               hi   = swap;
            end
         end
         1: begin
            lo = $urandom;
            hi = $urandom;
         end
         2: begin
            lo = 32'h80000000;
            hi = 32'h7fffffff;
         end
         default: begin
            lo = book.low_limit;
            hi = book.high_limit;
         end
      endcase
      csr_write(CSR_HIGH_LIMIT, hi);
      csr_write(CSR_LOW_LIMIT, lo);

      // Mostly legal lengths; now and then zero or above the ring depth
      if ($urandom_range(9) < 7) len = $urandom_range(1, MAX_WINDOW);
      else if ($urandom_range(1)) len = 0;
      else len = $urandom_range(MAX_WINDOW + 1, (1 << LEN_W) - 1);
      csr_write(CSR_WIN_LEN, {junk[CSR_DATA_W-1:LEN_W], len[LEN_W-1:0]});

      csr_write(CSR_AUTO_MODE, {junk[CSR_DATA_W-1:1], ($urandom_range(99) < 85) ? 1'b1 : 1'b0});

      if ($urandom_range(9) == 0) csr_write(UNMAPPED_INDEX, $urandom);
      settings_used++;
   endtask

   initial begin
      int unsigned phase;
      book.reset_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: gain 1.0, window 10, limits 0..100; corners saturate the total
      settings_used++;
      foreach (corner_samples[i]) begin
         send_sample(corner_samples[i]);
         sender_gap();
      end

      // Largest positive gain, window length zero (acts as one), limits wide open
      drain();
      csr_write(CSR_GAIN, 32'h007fffff);
      csr_write(CSR_WIN_LEN, 32'h00000000);
      csr_write(CSR_HIGH_LIMIT, 32'h7fffffff);
      csr_write(CSR_LOW_LIMIT, 32'h80000000);
      settings_used++;
      send_sample(32'h00000001);
      send_sample(32'h00010000);
      send_sample(32'hffffffff);
      send_sample(32'h7fffffff);

      // Most negative gain, length above the ring depth, inverted limits,
      // and a write to an index the block ignores
      drain();
      csr_write(CSR_GAIN, 32'hff800000);
      csr_write(CSR_WIN_LEN, 32'hffffffff);
      csr_write(UNMAPPED_INDEX, 32'h5a5a5a5a);
      csr_write(CSR_LOW_LIMIT, 32'h7fffffff);
      csr_write(CSR_HIGH_LIMIT, 32'h80000000);
      settings_used++;
      send_sample(32'h00030000);
      send_sample(32'h80000000);
      send_sample(32'h7fffffff);
      send_sample(32'hfffe0000);

      // Manual mode: total holds and no state moves; flag follows the new limits
      drain();
      csr_write(CSR_AUTO_MODE, 32'hfffffffe);
      csr_write(CSR_HIGH_LIMIT, 32'h00000000);
      csr_write(CSR_LOW_LIMIT, 32'hffff0000);
      settings_used++;
      send_sample(32'h12345678);
      send_sample(32'h80000000);
      send_sample(32'h7fffffff);

      // Back to auto at unity gain over the full ring
      drain();
      csr_write(CSR_AUTO_MODE, 32'h00000001);
      csr_write(CSR_GAIN, 32'h00010000);
      csr_write(CSR_WIN_LEN, MAX_WINDOW);
      csr_write(CSR_HIGH_LIMIT, 32'h00640000);
      csr_write(CSR_LOW_LIMIT, 32'hff9c0000);
      settings_used++;
      send_sample(32'h00010000);
      send_sample(32'h00020000);
      send_sample(32'hffff8000);
      send_sample(32'h00050000);
      send_sample(32'h00000003);

      // Shrink the window under the pointer: the entry there is still used, then wrap
      drain();
      csr_write(CSR_WIN_LEN, 32'h00000003);
      settings_used++;
      send_sample(32'h00040000);
      send_sample(32'hfffc0000);
      send_sample(32'h00008001);

      // Random phases: new settings each time, drained before every change.
      // One phase holds the receiver off while samples keep coming; one runs
      // with no idling on either side.
      phase = 0;
      while (samples_sent < ITEM_TARGET) begin
         drain();
         pick_settings();
         if (phase == HOLDOFF_PHASE) holdoff_requests <= holdoff_requests + 1;
         steady_run <= (phase == STEADY_PHASE);
         if (phase == STEADY_PHASE) send_run(80);
         else if (phase == HOLDOFF_PHASE) send_run(40);
         else send_run($urandom_range(15, 50));
         phase++;
      end
      drain();
      steady_run <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d samples over %0d register settings: gain and sample extremes,",
               samples_sent, settings_used);
      $display("window lengths 0..31, manual mode, shrunk windows; %0d totals checked, %0d %s, %0d saturated",
               book.checked, book.flagged, "out of limits", book.saturated);
      if (book.errors == 0 && book.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", book.errors, book.pending());
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run here
   initial begin
      #TIMEOUT_NS;
      $display("%0t: timeout with %0d results outstanding", $time, book.pending());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
